// File: hdl/matinv_pkg.sv
package matinv_pkg;

  localparam int LANES     = 9;
  localparam int TOL_W     = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  // element indices (row-major) of the two products of each cofactor: a*b - c*d
  localparam int COF_SRC [LANES][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // cofactors that multiply the first row in the determinant
  localparam int DET_COF [3] = '{0, 3, 6};

  typedef struct packed {
    logic vld;
    logic sing;
    logic neg;
    logic sat;
  } matinv_ctl_t;

endpackage

// File: hdl/matrix3_inverse_top.sv
// channel | ports                              | transfer
// input   | start, busy, in_a00 .. in_a22      | start high and busy low at a clock edge
// result  | out_valid, out_r00 .. out_saturated| out_valid high for one cycle
// config  | cfg_valid, cfg_ready, cfg_data     | cfg_valid and cfg_ready high
// one matrix per cycle; busy stays low, the pipeline never holds
// a result passes the cofactor, determinant and divider pipelines; the divider width XW is
// max(DATA_WIDTH+FRAC_BITS, 2*DATA_WIDTH+1-FRAC_BITS)+1 in the one-bit-per-stage
// restoring divider of each of the nine lanes
// reset is synchronous on rst_n and clears valid bits and the tolerance (to 7)
// the receiver cannot stall: a result is on the ports for exactly one cycle
module matrix3_inverse_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [DATA_WIDTH-1:0]      in_a00,
  input  logic signed [DATA_WIDTH-1:0]      in_a01,
  input  logic signed [DATA_WIDTH-1:0]      in_a02,
  input  logic signed [DATA_WIDTH-1:0]      in_a10,
  input  logic signed [DATA_WIDTH-1:0]      in_a11,
  input  logic signed [DATA_WIDTH-1:0]      in_a12,
  input  logic signed [DATA_WIDTH-1:0]      in_a20,
  input  logic signed [DATA_WIDTH-1:0]      in_a21,
  input  logic signed [DATA_WIDTH-1:0]      in_a22,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_r00,
  output logic signed [DATA_WIDTH-1:0]      out_r01,
  output logic signed [DATA_WIDTH-1:0]      out_r02,
  output logic signed [DATA_WIDTH-1:0]      out_r10,
  output logic signed [DATA_WIDTH-1:0]      out_r11,
  output logic signed [DATA_WIDTH-1:0]      out_r12,
  output logic signed [DATA_WIDTH-1:0]      out_r20,
  output logic signed [DATA_WIDTH-1:0]      out_r21,
  output logic signed [DATA_WIDTH-1:0]      out_r22,
  output logic signed [DATA_WIDTH-1:0]      out_determinant,
  output logic                              out_singular,
  output logic                              out_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [matinv_pkg::TOL_W-1:0]      cfg_data
);
  import matinv_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DETW = 2 * W + 2 - F;
  localparam int NUMW = W + F;
  localparam int XW   = ((NUMW > DETW - 1) ? NUMW : DETW - 1) + 1;
  localparam int DL   = XW + 2;

  logic [TOL_W-1:0]    tol_r;
  logic signed [W-1:0] a [LANES];
  logic signed [W-1:0] cof_w [LANES];
  logic                csat_w [LANES];
  logic                cvld_w [LANES];
  logic signed [W-1:0] a0_r [2][3];
  logic signed [W-1:0] cofd_r [3][LANES];
  logic                csatd_r [3];
  logic                csat_any;
  matinv_ctl_t         dctl_w, lctl;
  logic [DETW-1:0]     mag_w;
  logic signed [W-1:0] det_w;
  logic signed [W-1:0] detd_r [DL];
  logic                singd_r [DL];
  logic                satd_r [DL];
  matinv_ctl_t         octl_w [LANES];
  logic signed [W-1:0] r_w [LANES];
  logic                lsat_any;
  logic                out_valid_r, sing_r, sat_r;
  logic signed [W-1:0] r_r [LANES];
  logic signed [W-1:0] det_r;

  assign a = '{in_a00, in_a01, in_a02, in_a10, in_a11, in_a12, in_a20, in_a21, in_a22};

  for (genvar i = 0; i < LANES; i++) begin : g_cof
    matinv_cof #(.W(W), .F(F)) u_cof (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (start),
      .a       (a[COF_SRC[i][0]]),
      .b       (a[COF_SRC[i][1]]),
      .c       (a[COF_SRC[i][2]]),
      .d       (a[COF_SRC[i][3]]),
      .out_vld (cvld_w[i]),
      .cof     (cof_w[i]),
      .sat     (csat_w[i])
    );
  end

  always_comb begin
    csat_any = 1'b0;
    for (int i = 0; i < LANES; i++) csat_any = csat_any | csat_w[i];
  end

  matinv_det #(.W(W), .F(F)) u_det (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (cvld_w[0]),
    .a0     (a0_r[1][0]),
    .a1     (a0_r[1][1]),
    .a2     (a0_r[1][2]),
    .c0     (cof_w[DET_COF[0]]),
    .c1     (cof_w[DET_COF[1]]),
    .c2     (cof_w[DET_COF[2]]),
    .tol    (tol_r),
    .ctl    (dctl_w),
    .mag    (mag_w),
    .det    (det_w)
  );

  always_comb begin
    lctl     = dctl_w;
    lctl.sat = dctl_w.sat | csatd_r[2];
  end

  for (genvar i = 0; i < LANES; i++) begin : g_div
    matinv_div #(.W(W), .F(F)) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (lctl),
      .cof   (cofd_r[2][i]),
      .mag   (mag_w),
      .ctl_o (octl_w[i]),
      .r     (r_w[i])
    );
  end

  always_comb begin
    lsat_any = 1'b0;
    for (int i = 0; i < LANES; i++) lsat_any = lsat_any | octl_w[i].sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) tol_r <= cfg_data;
      out_valid_r <= octl_w[0].vld;
    end
    a0_r[0]    <= '{in_a00, in_a01, in_a02};
    a0_r[1]    <= a0_r[0];
    cofd_r[0]  <= cof_w;
    cofd_r[1]  <= cofd_r[0];
    cofd_r[2]  <= cofd_r[1];
    csatd_r[0] <= csat_any;
    csatd_r[1] <= csatd_r[0];
    csatd_r[2] <= csatd_r[1];
    detd_r[0]  <= det_w;
    singd_r[0] <= dctl_w.sing;
    satd_r[0]  <= lctl.sat;
    for (int k = 1; k < DL; k++) begin
      detd_r[k]  <= detd_r[k-1];
      singd_r[k] <= singd_r[k-1];
      satd_r[k]  <= satd_r[k-1];
    end
    r_r    <= r_w;
    det_r  <= detd_r[DL-1];
    sing_r <= singd_r[DL-1];
    sat_r  <= satd_r[DL-1] | lsat_any;
  end

  assign busy            = 1'b0;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_r00         = r_r[0];
  assign out_r01         = r_r[1];
  assign out_r02         = r_r[2];
  assign out_r10         = r_r[3];
  assign out_r11         = r_r[4];
  assign out_r12         = r_r[5];
  assign out_r20         = r_r[6];
  assign out_r21         = r_r[7];
  assign out_r22         = r_r[8];
  assign out_determinant = det_r;
  assign out_singular    = sing_r;
  assign out_saturated   = sat_r;

endmodule

// File: hdl/matinv_cof.sv
module matinv_cof #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [W-1:0] c,
  input  logic signed [W-1:0] d,
  output logic                out_vld,
  output logic signed [W-1:0] cof,
  output logic                sat
);
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int RW = SW - F;
  localparam logic signed [SW-1:0] HALF = SW'((64'(1) << F) >> 1);
  localparam logic signed [RW-1:0] MAXV = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] MINV = ~MAXV;

  logic signed [PW-1:0] p0_r, p1_r;
  logic                 vld_r, out_vld_r, sat_r;
  logic signed [W-1:0]  cof_r, cof_nxt;
  logic                 sat_nxt;
  logic signed [SW-1:0] sum;
  logic signed [RW-1:0] rnd;

  always_comb begin
    sum = SW'(p0_r) - SW'(p1_r);
    rnd = RW'((sum + HALF) >>> F);
    sat_nxt = 1'b0;
    cof_nxt = rnd[W-1:0];
    if (rnd > MAXV) begin
      cof_nxt = MAXV[W-1:0];
      sat_nxt = 1'b1;
    end else if (rnd < MINV) begin
      cof_nxt = MINV[W-1:0];
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= in_vld;
      out_vld_r <= vld_r;
    end
    p0_r  <= a * b;
    p1_r  <= c * d;
    cof_r <= cof_nxt;
    sat_r <= sat_nxt;
  end

  assign out_vld = out_vld_r;
  assign cof     = cof_r;
  assign sat     = sat_r;

endmodule

// File: hdl/matinv_det.sv
module matinv_det #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [W-1:0]            a0,
  input  logic signed [W-1:0]            a1,
  input  logic signed [W-1:0]            a2,
  input  logic signed [W-1:0]            c0,
  input  logic signed [W-1:0]            c1,
  input  logic signed [W-1:0]            c2,
  input  logic [matinv_pkg::TOL_W-1:0]   tol,
  output matinv_pkg::matinv_ctl_t        ctl,
  output logic [2*W+2-F-1:0]             mag,
  output logic signed [W-1:0]            det
);
  import matinv_pkg::*;

  localparam int PW   = 2 * W;
  localparam int SW   = 2 * W + 2;
  localparam int DETW = SW - F;
  localparam logic signed [SW-1:0]   HALF = SW'((64'(1) << F) >> 1);
  localparam logic signed [DETW-1:0] MAXV = {{(DETW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [DETW-1:0] MINV = ~MAXV;

  logic signed [PW-1:0]   t0_r, t1_r, t2_r;
  logic signed [DETW-1:0] detw_r;
  logic                   vld1_r, vld2_r;
  logic signed [SW-1:0]   sum;
  matinv_ctl_t            ctl_r, ctl_nxt;
  logic [DETW-1:0]        mag_r, mag_nxt;
  logic signed [W-1:0]    det_r, det_nxt;

  always_comb begin
    sum = SW'(t0_r) + SW'(t1_r) + SW'(t2_r);
  end

  always_comb begin
    ctl_nxt.vld  = vld2_r;
    ctl_nxt.neg  = detw_r[DETW-1];
    mag_nxt      = detw_r[DETW-1] ? DETW'(-detw_r) : DETW'(detw_r);
    ctl_nxt.sing = (mag_nxt <= tol);
    ctl_nxt.sat  = 1'b0;
    det_nxt      = detw_r[W-1:0];
    if (detw_r > MAXV) begin
      det_nxt     = MAXV[W-1:0];
      ctl_nxt.sat = 1'b1;
    end else if (detw_r < MINV) begin
      det_nxt     = MINV[W-1:0];
      ctl_nxt.sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      ctl_r.vld <= 1'b0;
    end else begin
      vld1_r    <= in_vld;
      vld2_r    <= vld1_r;
      ctl_r.vld <= ctl_nxt.vld;
    end
    t0_r       <= a0 * c0;
    t1_r       <= a1 * c1;
    t2_r       <= a2 * c2;
    detw_r     <= DETW'((sum + HALF) >>> F);
    ctl_r.sing <= ctl_nxt.sing;
    ctl_r.neg  <= ctl_nxt.neg;
    ctl_r.sat  <= ctl_nxt.sat;
    mag_r      <= mag_nxt;
    det_r      <= det_nxt;
  end

  assign ctl = ctl_r;
  assign mag = mag_r;
  assign det = det_r;

endmodule

// File: hdl/matinv_div.sv
module matinv_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  matinv_pkg::matinv_ctl_t ctl_i,
  input  logic signed [W-1:0]     cof,
  input  logic [2*W+2-F-1:0]      mag,
  output matinv_pkg::matinv_ctl_t ctl_o,
  output logic signed [W-1:0]     r
);
  import matinv_pkg::*;

  localparam int DETW = 2 * W + 2 - F;
  localparam int NUMW = W + F;
  localparam int XW   = ((NUMW > DETW - 1) ? NUMW : DETW - 1) + 1;
  localparam int RW   = DETW + 1;
  localparam logic [XW-1:0] MAXQ = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [XW-1:0] MINQ = MAXQ + XW'(1);

  logic [XW-1:0]   x_r    [0:XW];
  logic [XW-1:0]   q_r    [0:XW];
  logic [RW-1:0]   rem_r  [0:XW];
  logic [DETW-1:0] d_r    [0:XW];
  logic            neg_r  [0:XW];
  logic            sing_r [0:XW];
  logic            vld_r  [0:XW];
  logic [RW-1:0]   trial  [0:XW-1];
  logic            ge     [0:XW-1];
  logic [W-1:0]    cmag;
  matinv_ctl_t     ctl_r, ctl_nxt;
  logic signed [W-1:0] r_r, r_nxt;
  logic [XW-1:0]   q;

  assign cmag = cof[W-1] ? W'(-cof) : W'(cof);

  always_comb begin
    for (int k = 0; k < XW; k++) begin
      trial[k] = {rem_r[k][RW-2:0], x_r[k][XW-1]};
      ge[k]    = (trial[k] >= {1'b0, d_r[k]});
    end
  end

  always_comb begin
    q           = q_r[XW];
    ctl_nxt.vld  = vld_r[XW];
    ctl_nxt.sing = sing_r[XW];
    ctl_nxt.neg  = neg_r[XW];
    ctl_nxt.sat  = 1'b0;
    r_nxt        = '0;
    if (!sing_r[XW]) begin
      if (neg_r[XW]) begin
        if (q > MINQ) begin
          r_nxt       = MINQ[W-1:0];
          ctl_nxt.sat = 1'b1;
        end else begin
          r_nxt = -q[W-1:0];
        end
      end else if (q > MAXQ) begin
        r_nxt       = MAXQ[W-1:0];
        ctl_nxt.sat = 1'b1;
      end else begin
        r_nxt = q[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= XW; k++) vld_r[k] <= 1'b0;
      ctl_r.vld <= 1'b0;
    end else begin
      vld_r[0] <= ctl_i.vld;
      for (int k = 0; k < XW; k++) vld_r[k+1] <= vld_r[k];
      ctl_r.vld <= ctl_nxt.vld;
    end
    x_r[0]    <= (XW'(cmag) << F) + XW'(mag >> 1);
    q_r[0]    <= '0;
    rem_r[0]  <= '0;
    d_r[0]    <= mag;
    neg_r[0]  <= cof[W-1] ^ ctl_i.neg;
    sing_r[0] <= ctl_i.sing;
    for (int k = 0; k < XW; k++) begin
      x_r[k+1]    <= x_r[k] << 1;
      q_r[k+1]    <= {q_r[k][XW-2:0], ge[k]};
      rem_r[k+1]  <= ge[k] ? trial[k] - {1'b0, d_r[k]} : trial[k];
      d_r[k+1]    <= d_r[k];
      neg_r[k+1]  <= neg_r[k];
      sing_r[k+1] <= sing_r[k];
    end
    ctl_r.sing <= ctl_nxt.sing;
    ctl_r.neg  <= ctl_nxt.neg;
    ctl_r.sat  <= ctl_nxt.sat;
    r_r        <= r_nxt;
  end

  assign ctl_o = ctl_r;
  assign r     = r_r;

endmodule
